### hdl/dau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dau_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int VEC_W = COORD_WIDTH + 1;
  localparam int NRM_W = 2 * VEC_W + 1;
  localparam int NORM_BITS = 30;
  localparam int PQ_W = NORM_BITS + 1;
  localparam int PROD_W = 2 * PQ_W;
  localparam int TRI_W = PROD_W + 2;
  localparam int SQ_W = 2 * NORM_BITS + 2;
  localparam int CORDIC_STEPS = 29;
  localparam int CX_W = NORM_BITS + 6;
  localparam int CZ_W = 33;
  localparam int QUARTER_TURN = 589824000;
  localparam logic [30:0] SCALE_Q30 = 31'd1073742731;
  localparam int SCALE_SHIFT = 46;
  localparam int ANGLE_W = 16;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [COORD_WIDTH-1:0] dx;
    logic signed [COORD_WIDTH-1:0] dy;
    logic signed [COORD_WIDTH-1:0] dz;
  } dau_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      undefined;
  } dau_out_t;

endpackage

`default_nettype wire

### hdl/dau_vec.sv
`timescale 1ns / 1ps
`default_nettype none

module dau_vec (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  dau_pkg::dau_in_t                    in_data,
  output logic                                out_valid,
  output logic signed [dau_pkg::NRM_W-1:0]    n1 [3],
  output logic signed [dau_pkg::NRM_W-1:0]    n2 [3],
  output logic                                ss_neg
);

  localparam int VW = dau_pkg::VEC_W;
  localparam int NW = dau_pkg::NRM_W;
  localparam int PW = 2 * VW;
  localparam int SPL = (NW + 1) / 2;
  localparam int HW = NW - SPL;
  localparam int HPW = VW + HW;
  localparam int LPW = VW + SPL + 1;
  localparam int SW = VW + NW + 2;

  logic [4:0] vld_r;
  logic signed [dau_pkg::COORD_WIDTH-1:0] pa [3], pb [3], pc [3], pd [3];
  logic signed [VW-1:0] v12_r [3], v23_r [3], v34_r [3];
  logic signed [VW-1:0] v12_2_r [3], v12_3_r [3];
  logic signed [PW-1:0] pa1_r [3], pb1_r [3], pa2_r [3], pb2_r [3];
  logic signed [NW-1:0] n1_r [3], n2_r [3], n1_4_r [3], n2_4_r [3], n1_5_r [3], n2_5_r [3];
  logic signed [HPW-1:0] ph_r [3];
  logic signed [LPW-1:0] pl_r [3];
  logic signed [SW-1:0] ss_nxt;
  logic ss_neg_r;

  always_comb begin
    pa[0] = in_data.ax;  pa[1] = in_data.ay;        pa[2] = in_data.az;
    pb[0] = in_data.bx;  pb[1] = in_data.by_coord;  pb[2] = in_data.bz;
    pc[0] = in_data.cx;  pc[1] = in_data.cy;        pc[2] = in_data.cz;
    pd[0] = in_data.dx;  pd[1] = in_data.dy;        pd[2] = in_data.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_axis
    localparam int A = (j + 1) % 3;
    localparam int B = (j + 2) % 3;

    always_ff @(posedge clk) begin
      v12_r[j]   <= VW'(pb[j]) - VW'(pa[j]);
      v23_r[j]   <= VW'(pc[j]) - VW'(pb[j]);
      v34_r[j]   <= VW'(pd[j]) - VW'(pc[j]);
      pa1_r[j]   <= PW'(v12_r[A]) * PW'(v23_r[B]);
      pb1_r[j]   <= PW'(v12_r[B]) * PW'(v23_r[A]);
      pa2_r[j]   <= PW'(v23_r[A]) * PW'(v34_r[B]);
      pb2_r[j]   <= PW'(v23_r[B]) * PW'(v34_r[A]);
      v12_2_r[j] <= v12_r[j];
      n1_r[j]    <= NW'(pa1_r[j]) - NW'(pb1_r[j]);
      n2_r[j]    <= NW'(pa2_r[j]) - NW'(pb2_r[j]);
      v12_3_r[j] <= v12_2_r[j];
      ph_r[j]    <= HPW'(v12_3_r[j]) * HPW'(signed'(n2_r[j][NW-1:SPL]));
      pl_r[j]    <= LPW'(v12_3_r[j]) * LPW'(signed'({1'b0, n2_r[j][SPL-1:0]}));
      n1_4_r[j]  <= n1_r[j];
      n2_4_r[j]  <= n2_r[j];
      n1_5_r[j]  <= n1_4_r[j];
      n2_5_r[j]  <= n2_4_r[j];
    end
  end

  always_comb begin
    ss_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      ss_nxt = ss_nxt + (SW'(ph_r[j]) <<< SPL) + SW'(pl_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    ss_neg_r <= ss_nxt[SW-1];
  end

  assign out_valid = vld_r[4];
  assign n1 = n1_5_r;
  assign n2 = n2_5_r;
  assign ss_neg = ss_neg_r;

endmodule

`default_nettype wire

### hdl/dau_norm.sv
`timescale 1ns / 1ps
`default_nettype none

module dau_norm #(
  parameter int G  = 1,
  parameter int N  = 4,
  parameter int IW = 64,
  parameter int TW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [TW-1:0]                     in_tag,
  input  logic signed [IW-1:0]              in_val [G][N],
  output logic                              out_valid,
  output logic [TW-1:0]                     out_tag,
  output logic signed [dau_pkg::PQ_W-1:0]   out_val [G][N],
  output logic [G-1:0]                      out_zero
);

  localparam int NB = dau_pkg::NORM_BITS;
  localparam int NC = (IW + 7) / 8;
  localparam int LW = $clog2(IW + 1);

  logic [3:0] vld_r;
  logic [TW-1:0] tag_r [4];
  logic [IW-1:0] mag1_r [G][N], mag2_r [G][N], mag3_r [G][N];
  logic neg1_r [G][N], neg2_r [G][N], neg3_r [G][N];
  logic [IW-1:0] orv [G];
  logic [NC*8-1:0] orw [G];
  logic [3:0] cl_nxt [G][NC];
  logic [3:0] cl_r [G][NC];
  logic [LW-1:0] len_nxt [G];
  logic [LW-1:0] len_r [G];
  logic [IW+NB-1:0] wide [G][N];
  logic signed [NB:0] val_nxt [G][N];
  logic signed [NB:0] val_r [G][N];
  logic [G-1:0] zero_nxt, zero_r;

  function automatic logic [3:0] blen8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      if (v[b]) n = 4'(b + 1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_comb begin
    for (int g = 0; g < G; g++) begin
      orv[g] = '0;
      for (int i = 0; i < N; i++) begin
        orv[g] = orv[g] | mag1_r[g][i];
      end
      orw[g] = (NC*8)'(orv[g]);
      for (int k = 0; k < NC; k++) begin
        cl_nxt[g][k] = blen8(orw[g][k*8 +: 8]);
      end
      len_nxt[g] = '0;
      for (int k = 0; k < NC; k++) begin
        if (cl_r[g][k] != 4'd0) len_nxt[g] = LW'(k * 8) + LW'(cl_r[g][k]);
      end
      zero_nxt[g] = (len_r[g] == '0);
      for (int i = 0; i < N; i++) begin
        wide[g][i] = {mag3_r[g][i], {NB{1'b0}}} >> len_r[g];
        val_nxt[g][i] = neg3_r[g][i] ? -signed'({1'b0, wide[g][i][NB-1:0]})
                                     : signed'({1'b0, wide[g][i][NB-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 1; s < 4; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    for (int g = 0; g < G; g++) begin
      for (int i = 0; i < N; i++) begin
        neg1_r[g][i] <= in_val[g][i][IW-1];
        mag1_r[g][i] <= in_val[g][i][IW-1] ? IW'(-in_val[g][i]) : IW'(in_val[g][i]);
        mag2_r[g][i] <= mag1_r[g][i];
        neg2_r[g][i] <= neg1_r[g][i];
        mag3_r[g][i] <= mag2_r[g][i];
        neg3_r[g][i] <= neg2_r[g][i];
        val_r[g][i]  <= val_nxt[g][i];
      end
      for (int k = 0; k < NC; k++) begin
        cl_r[g][k] <= cl_nxt[g][k];
      end
      len_r[g] <= len_nxt[g];
    end
    zero_r <= zero_nxt;
  end

  assign out_valid = vld_r[3];
  assign out_tag = tag_r[3];
  assign out_val = val_r;
  assign out_zero = zero_r;

endmodule

`default_nettype wire

### hdl/dau_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module dau_isqrt #(
  parameter int TW = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [TW-1:0]                  in_tag,
  input  logic [dau_pkg::SQ_W-1:0]       in_x,
  output logic                           out_valid,
  output logic [TW-1:0]                  out_tag,
  output logic [dau_pkg::PQ_W-1:0]       out_root
);

  localparam int XW = dau_pkg::SQ_W;
  localparam int ST = XW / 2;

  logic vld_r [ST];
  logic [TW-1:0] tag_r [ST];
  logic [XW-1:0] rem_r [ST];
  logic [XW-1:0] res_r [ST];

  for (genvar s = 0; s < ST; s++) begin : g_step
    localparam int K = ST - 1 - s;
    localparam logic [XW-1:0] BITV = XW'(1) << (2 * K);
    logic [XW-1:0] rem_in, res_in;
    logic [TW-1:0] tag_in;
    logic vld_in;
    logic [XW:0] trial;
    logic take;

    if (s == 0) begin : g_first
      assign rem_in = in_x;
      assign res_in = '0;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign res_in = res_r[s-1];
      assign tag_in = tag_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BITV};
    assign take = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      tag_r[s] <= tag_in;
      rem_r[s] <= take ? rem_in - trial[XW-1:0] : rem_in;
      res_r[s] <= take ? (res_in >> 1) + BITV : res_in >> 1;
    end
  end

  assign out_valid = vld_r[ST-1];
  assign out_tag = tag_r[ST-1];
  assign out_root = res_r[ST-1][dau_pkg::PQ_W-1:0];

endmodule

`default_nettype wire

### hdl/dau_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module dau_cordic #(
  parameter int TW = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [TW-1:0]                      in_tag,
  input  logic signed [dau_pkg::PQ_W-1:0]    in_x,
  input  logic [dau_pkg::PQ_W-1:0]           in_y,
  output logic                               out_valid,
  output logic [TW-1:0]                      out_tag,
  output logic signed [dau_pkg::CZ_W-1:0]    out_z
);

  localparam int XW = dau_pkg::CX_W;
  localparam int ZW = dau_pkg::CZ_W;
  localparam int NS = dau_pkg::CORDIC_STEPS;

  logic vld0_r;
  logic [TW-1:0] tag0_r;
  logic signed [XW-1:0] x0_r, y0_r;
  logic signed [ZW-1:0] z0_r;
  logic vld_r [NS];
  logic [TW-1:0] tag_r [NS];
  logic signed [XW-1:0] x_r [NS], y_r [NS];
  logic signed [ZW-1:0] z_r [NS];
  logic signed [XW-1:0] xe, ye;

  assign xe = XW'(in_x);
  assign ye = XW'(signed'({1'b0, in_y}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag0_r <= in_tag;
    if (xe < 0) begin
      x0_r <= ye;
      y0_r <= -xe;
      z0_r <= ZW'(dau_pkg::QUARTER_TURN);
    end else begin
      x0_r <= xe;
      y0_r <= ye;
      z0_r <= '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = ZW'(dau_pkg::ATAN_TAB[i]);
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic [TW-1:0] ti;
    logic vi;

    if (i == 0) begin : g_first
      assign xi = x0_r;
      assign yi = y0_r;
      assign zi = z0_r;
      assign ti = tag0_r;
      assign vi = vld0_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ti = tag_r[i-1];
      assign vi = vld_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      tag_r[i] <= ti;
      if (yi > 0) begin
        x_r[i] <= xi + (yi >>> i);
        y_r[i] <= yi - (xi >>> i);
        z_r[i] <= zi + ANG;
      end else begin
        x_r[i] <= xi - (yi >>> i);
        y_r[i] <= yi + (xi >>> i);
        z_r[i] <= zi - ANG;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_tag = tag_r[NS-1];
  assign out_z = z_r[NS-1];

endmodule

`default_nettype wire

### hdl/dihedral_angle_unit.sv
// Torsion angle of four points, one request per clock.
//
// A request is taken at each rising edge where start is high and busy is
// low; busy stays low, so a new set of four points may be given in every
// cycle. Coordinates are signed, in thousandths of an angstrom.
// Each result stands on out_data for one cycle with out_valid high: the
// angle in hundredths of a degree, or zero with the undefined flag when a
// plane normal vanishes. Results leave in request order.
// The depth is set by the square root, one bit pair a stage over 31
// stages, and the angle CORDIC, a quarter-turn stage and then one
// iteration a stage over 29 stages; throughput is one result per cycle.
// The receiver cannot hold results off, so there is no back pressure.
// Synchronous reset clears every valid bit; requests in flight are lost.
`timescale 1ns / 1ps
`default_nettype none

module dihedral_angle_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dau_pkg::dau_in_t   in_data,
  output logic               out_valid,
  output dau_pkg::dau_out_t  out_data
);

  localparam int NW = dau_pkg::NRM_W;
  localparam int QW = dau_pkg::PQ_W;
  localparam int PW = dau_pkg::PROD_W;
  localparam int TT = dau_pkg::TRI_W;
  localparam int SQ = dau_pkg::SQ_W;
  localparam int ZW = dau_pkg::CZ_W;
  localparam int MW = ZW - 1 + 31;
  localparam int AW = dau_pkg::ANGLE_W;

  logic vec_valid, vec_ss_neg;
  logic signed [NW-1:0] vec_n1 [3], vec_n2 [3];
  logic signed [NW-1:0] nrm_in [2][3];
  logic nrm_valid;
  logic [0:0] nrm_tag;
  logic signed [QW-1:0] pq [2][3];
  logic [1:0] nrm_zero;

  logic vld_t1_r, vld_t2_r, vld_t3_r, vld_t4_r;
  logic [1:0] tag_t1_r, tag_t2_r, tag_t3_r, tag_t4_r;
  logic signed [PW-1:0] dot_r [3], ca_r [3], cb_r [3];
  logic signed [TT-1:0] tv_r [1][4];

  logic g_valid;
  logic [1:0] g_tag;
  logic signed [QW-1:0] gv [1][4];
  logic [0:0] g_zero;

  logic [SQ-1:0] sq_r [3];
  logic [SQ-1:0] ssum_r;
  logic signed [QW-1:0] x3_r, x4_r;

  logic iq_valid;
  logic [QW+1:0] iq_tag;
  logic [QW-1:0] iq_root;

  logic cd_valid;
  logic [1:0] cd_tag;
  logic signed [ZW-1:0] cd_z;

  logic vld_f1_r, out_valid_r;
  logic [1:0] tag_f1_r;
  logic [MW-1:0] prod_r;
  logic [MW-1:0] prod_rnd;
  logic [AW-2:0] mag_a;
  dau_pkg::dau_out_t out_nxt, out_r;

  assign busy = 1'b0;

  dau_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .out_valid (vec_valid),
    .n1        (vec_n1),
    .n2        (vec_n2),
    .ss_neg    (vec_ss_neg)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrm_in[0][j] = vec_n1[j];
      nrm_in[1][j] = vec_n2[j];
    end
  end

  dau_norm #(.G(2), .N(3), .IW(NW), .TW(1)) u_norm_n (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_valid),
    .in_tag    (vec_ss_neg),
    .in_val    (nrm_in),
    .out_valid (nrm_valid),
    .out_tag   (nrm_tag),
    .out_val   (pq),
    .out_zero  (nrm_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_t1_r <= 1'b0;
      vld_t2_r <= 1'b0;
      vld_t3_r <= 1'b0;
      vld_t4_r <= 1'b0;
      vld_f1_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_t1_r <= nrm_valid;
      vld_t2_r <= vld_t1_r;
      vld_t3_r <= g_valid;
      vld_t4_r <= vld_t3_r;
      vld_f1_r <= cd_valid;
      out_valid_r <= vld_f1_r;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_pq
    localparam int A = (j + 1) % 3;
    localparam int B = (j + 2) % 3;

    always_ff @(posedge clk) begin
      dot_r[j] <= PW'(pq[0][j]) * PW'(pq[1][j]);
      ca_r[j]  <= PW'(pq[0][A]) * PW'(pq[1][B]);
      cb_r[j]  <= PW'(pq[0][B]) * PW'(pq[1][A]);
      tv_r[0][j+1] <= TT'(ca_r[j]) - TT'(cb_r[j]);
      sq_r[j]  <= SQ'(PW'(gv[0][j+1]) * PW'(gv[0][j+1]));
    end
  end

  always_ff @(posedge clk) begin
    tag_t1_r <= {nrm_tag[0], |nrm_zero};
    tv_r[0][0] <= TT'(dot_r[0]) + TT'(dot_r[1]) + TT'(dot_r[2]);
    tag_t2_r <= tag_t1_r;
    x3_r <= gv[0][0];
    tag_t3_r <= {g_tag[1], g_tag[0] | g_zero[0]};
    ssum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    x4_r <= x3_r;
    tag_t4_r <= tag_t3_r;
  end

  dau_norm #(.G(1), .N(4), .IW(TT), .TW(2)) u_norm_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_t2_r),
    .in_tag    (tag_t2_r),
    .in_val    (tv_r),
    .out_valid (g_valid),
    .out_tag   (g_tag),
    .out_val   (gv),
    .out_zero  (g_zero)
  );

  dau_isqrt #(.TW(QW + 2)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_t4_r),
    .in_tag    ({x4_r, tag_t4_r}),
    .in_x      (ssum_r),
    .out_valid (iq_valid),
    .out_tag   (iq_tag),
    .out_root  (iq_root)
  );

  dau_cordic #(.TW(2)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (iq_valid),
    .in_tag    (iq_tag[1:0]),
    .in_x      (signed'(iq_tag[QW+1:2])),
    .in_y      (iq_root),
    .out_valid (cd_valid),
    .out_tag   (cd_tag),
    .out_z     (cd_z)
  );

  always_ff @(posedge clk) begin
    tag_f1_r <= cd_tag;
    prod_r <= (cd_z > 0) ? MW'(cd_z[ZW-2:0]) * MW'(dau_pkg::SCALE_Q30) : '0;
  end

  always_comb begin
    prod_rnd = prod_r + (MW'(1) << (dau_pkg::SCALE_SHIFT - 1));
    mag_a = prod_rnd[dau_pkg::SCALE_SHIFT +: AW-1];
    out_nxt.undefined = tag_f1_r[0];
    if (tag_f1_r[0]) begin
      out_nxt.angle = '0;
    end else if (tag_f1_r[1]) begin
      out_nxt.angle = -signed'({1'b0, mag_a});
    end else begin
      out_nxt.angle = signed'({1'b0, mag_a});
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int N_RANDOM = 1650;
  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 200000;

  class torsion_scoreboard;
    dau_pkg::dau_out_t pending[$];
    int errors;
    int checked;
    int undef_seen;
    int neg_seen;

    static function automatic int bit_length(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
        n++;
        v >>= 1;
      end
      return n;
    endfunction

    static function automatic bit scale_to_30(input longint v[4], input int cnt,
                                              output longint o[4]);
      longint unsigned mag[4];
      int len;
      int b;
      len = 0;
      for (int i = 0; i < 4; i++) begin
        o[i] = 0;
        mag[i] = 0;
      end
      for (int i = 0; i < cnt; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        b = bit_length(mag[i]);
        if (b > len) len = b;
      end
      for (int i = 0; i < cnt; i++) begin
        if (len > dau_pkg::NORM_BITS) mag[i] = mag[i] >> (len - dau_pkg::NORM_BITS);
        else mag[i] = mag[i] << (dau_pkg::NORM_BITS - len);
        o[i] = v[i] < 0 ? -longint'(mag[i]) : longint'(mag[i]);
      end
      return len != 0;
    endfunction

    static function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function automatic dau_pkg::dau_out_t torsion_of(dau_pkg::dau_in_t d);
      longint pa[3], pb[3], pc[3], pd[3];
      longint v12[3], v23[3], v34[3];
      longint n1[4], n2[4], p[4], q[4], t[4], g[4];
      logic signed [127:0] triple;
      longint unsigned sq, mag;
      longint x, y, z, nx, xs, ys, ang;
      dau_pkg::dau_out_t r;
      pa = '{longint'(d.ax), longint'(d.ay), longint'(d.az)};
      pb = '{longint'(d.bx), longint'(d.by_coord), longint'(d.bz)};
      pc = '{longint'(d.cx), longint'(d.cy), longint'(d.cz)};
      pd = '{longint'(d.dx), longint'(d.dy), longint'(d.dz)};
      for (int j = 0; j < 3; j++) begin
        v12[j] = pb[j] - pa[j];
        v23[j] = pc[j] - pb[j];
        v34[j] = pd[j] - pc[j];
      end
      n1 = '{v12[1]*v23[2] - v12[2]*v23[1], v12[2]*v23[0] - v12[0]*v23[2],
             v12[0]*v23[1] - v12[1]*v23[0], 0};
      n2 = '{v23[1]*v34[2] - v23[2]*v34[1], v23[2]*v34[0] - v23[0]*v34[2],
             v23[0]*v34[1] - v23[1]*v34[0], 0};
      r = '0;
      if (!scale_to_30(n1, 3, p) || !scale_to_30(n2, 3, q)) begin
        r.undefined = 1'b1;
        return r;
      end
      triple = 128'sd0;
      for (int j = 0; j < 3; j++)
        triple += 128'(signed'(v12[j])) * 128'(signed'(n2[j]));
      t = '{p[0]*q[0] + p[1]*q[1] + p[2]*q[2], p[1]*q[2] - p[2]*q[1],
            p[2]*q[0] - p[0]*q[2], p[0]*q[1] - p[1]*q[0]};
      void'(scale_to_30(t, 4, g));
      sq = longint'(g[1]*g[1]) + longint'(g[2]*g[2]) + longint'(g[3]*g[3]);
      x = g[0];
      y = longint'(root_floor(sq));
      z = 0;
      if (x < 0) begin
        nx = y;
        y = -x;
        x = nx;
        z = dau_pkg::QUARTER_TURN;
      end
      for (int i = 0; i < dau_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys;
          y -= xs;
          z += dau_pkg::ATAN_TAB[i];
        end else begin
          x -= ys;
          y += xs;
          z -= dau_pkg::ATAN_TAB[i];
        end
      end
      mag = z > 0 ? longint'(z) : 0;
      ang = longint'((mag * 64'(dau_pkg::SCALE_Q30) + (64'd1 << 45)) >> dau_pkg::SCALE_SHIFT);
      if (triple < 0) ang = -ang;
      r.angle = ang[dau_pkg::ANGLE_W-1:0];
      return r;
    endfunction

    function void note_request(dau_pkg::dau_in_t d);
      pending.push_back(torsion_of(d));
    endfunction

    function void check_result(dau_pkg::dau_out_t got);
      dau_pkg::dau_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: angle %0d undefined %0d", got.angle, got.undefined);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.undefined) undef_seen++;
      if (got.angle < 0) neg_seen++;
      if (got.angle !== want.angle) begin
        $error("angle: expected %0d, actual %0d", want.angle, got.angle);
        errors++;
      end
      if (got.undefined !== want.undefined) begin
        $error("undefined: expected %0d, actual %0d", want.undefined, got.undefined);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dau_pkg::dau_in_t in_data = '0;
  logic out_valid;
  dau_pkg::dau_out_t out_data;
  longint cycles = 0;
  bit idling_on = 1'b1;
  torsion_scoreboard sb = new();

  dihedral_angle_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dihedral_angle_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  task automatic send_request(dau_pkg::dau_in_t d);
    if (idling_on && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
    sb.note_request(d);
  endtask

  function automatic int near(int base, int spread);
    return base + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic dau_pkg::dau_in_t random_quad();
    dau_pkg::dau_in_t d;
    int kind;
    int bx, by, bz, s;
    kind = $urandom_range(0, 99);
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom};
    if (kind < 60) begin
      s = $urandom_range(0, 3) == 0 ? 500000 : 2000;
      bx = near(0, 8000000);
      by = near(0, 8000000);
      bz = near(0, 8000000);
      d = '{near(bx, s), near(by, s), near(bz, s), near(bx, s), near(by, s), near(bz, s),
            near(bx, s), near(by, s), near(bz, s), near(bx, s), near(by, s), near(bz, s)};
    end else if (kind < 75) begin
      d = '{near(0, 4), near(0, 4), near(0, 4), near(0, 4), near(0, 4), near(0, 4),
            near(0, 4), near(0, 4), near(0, 4), near(0, 4), near(0, 4), near(0, 4)};
    end else if (kind < 85) begin
      case ($urandom_range(0, 3))
        0: {d.bx, d.by_coord, d.bz} = {d.ax, d.ay, d.az};
        1: {d.cx, d.cy, d.cz} = {d.bx, d.by_coord, d.bz};
        2: {d.dx, d.dy, d.dz} = {d.cx, d.cy, d.cz};
        default: begin
          d.cx = 2 * d.bx - d.ax;
          d.cy = 2 * d.by_coord - d.ay;
          d.cz = 2 * d.bz - d.az;
        end
      endcase
    end
    return d;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request('{0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 2000, 1000, 0});
    send_request('{0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 0, 1000, 0});
    send_request('{0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 1000, 1000, 1000});
    send_request('{0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 1000, 1000, -1000});
    send_request('{0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 1500, 1000, -800});
    send_request('{0, 0, 0, 0, 0, 0, 1000, 1000, 0, 2000, 1000, 0});
    send_request('{0, 0, 0, 1000, 0, 0, 2000, 0, 0, 2000, 1000, 0});
    send_request('{0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 1000, 1000, 0});
    send_request('{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5});
    send_request('{-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                   8388607, 8388607, -8388608, 8388607, 8388607, 8388607});
    send_request('{8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
                   -8388608, -8388608, 8388607, -8388608, -8388608, -8388608});
    send_request('{-8388608, 0, 8388607, 8388607, -8388608, 0,
                   0, 8388607, -8388608, -8388608, -8388608, 8388607});
    send_request('{8388607, 0, 0, 0, 8388607, 0, 0, 0, 8388607, -8388608, -8388608, 0});
    send_request('{0, 0, 0, 1, 0, 0, 1, 1, 0, 2, 1, 1});
    send_request('{0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 2, 0});
    send_request('{-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, -1});
    send_request('{1000, 0, 0, 0, 0, 0, 0, 1000, 0, 1000, 1000, 0});
    send_request('{0, 0, 0, 1460, 0, 0, 1980, 1410, 0, 3440, 1410, 1});
    send_request('{0, 0, 0, 1460, 0, 0, 1980, 1410, 0, 3440, 1410, -1});

    for (int i = 0; i < N_RANDOM; i++) begin
      idling_on = !(i >= 600 && i < 900);
      send_request(random_quad());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Checked %0d torsion results, %0d undefined and %0d negative,",
             sb.checked, sb.undef_seen, sb.neg_seen);
    $display("over directed geometries, molecular-scale quads and full-range noise.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("dihedral_angle_unit regression: pass");
    end else begin
      $display("dihedral_angle_unit regression: fail");
    end
    $finish;
  end

endmodule
